/* rtl/spt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spt_pkg
// shared types, constants and tables of the path tracking steer unit
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int PATH_DEPTH_DEF = 256;

  // cordic widths: vectoring operands, angles, sin/cos results
  localparam int CW   = 54;
  localparam int ZW   = 20;
  localparam int TW   = 18;

  localparam int CORDIC_LAST = 12;

  localparam logic signed [ZW-1:0] ANG_PI      = 20'sd12868;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd6434;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 20'sd25736;
  localparam logic signed [CW-1:0] CORDIC_K30  = 54'sd652032874;
  localparam logic signed [CW-1:0] NORM_LO     = 54'sd1 <<< 40;
  localparam logic signed [CW-1:0] NORM_HI     = 54'sd1 <<< 41;
  localparam logic signed [CW-1:0] ROUND_HALF  = 54'sd1 <<< 15;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_GAIN      = 3'd1;
  localparam logic [2:0] REG_TSPEED    = 3'd2;
  localparam logic [2:0] REG_MINSPEED  = 3'd3;
  localparam logic [2:0] REG_STEER_LIM = 3'd4;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd5;

  localparam logic CMD_WAYPOINT = 1'b0;
  localparam logic CMD_POSE     = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } spt_wp_t;

  typedef struct packed {
    logic take_wp;
    logic take_pose;
    logic mod_load;
    logic mod_step;
    logic tgt_read;
    logic at_q;
    logic err_calc;
    logic wrap_step;
    logic sc_hd;
    logic cte_a;
    logic cte_b;
    logic gmul;
    logic at_g;
    logic steer_calc;
    logic sc_err;
    logic spd_mul;
    logic res_load;
  } spt_cmd_t;

  typedef struct packed {
    logic pose_ok;
    logic srch_done;
    logic mod_done;
    logic wrap_done;
    logic cordic_done;
    logic out_free;
  } spt_stat_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:    r = 20'sd3217;
      4'd1:    r = 20'sd1899;
      4'd2:    r = 20'sd1003;
      4'd3:    r = 20'sd509;
      4'd4:    r = 20'sd256;
      4'd5:    r = 20'sd128;
      4'd6:    r = 20'sd64;
      4'd7:    r = 20'sd32;
      4'd8:    r = 20'sd16;
      4'd9:    r = 20'sd8;
      4'd10:   r = 20'sd4;
      4'd11:   r = 20'sd2;
      4'd12:   r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/stanley_path_tracking_steer_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stanley_path_tracking_steer_unit
// path tracking steering controller with waypoint store
// ---------------------------------------------------------------------------
// input channel (in_valid / in_stall): cmd 0 stores a waypoint, cmd 1 is a
// pose item. a waypoint is taken and gives no result. a pose
// item gives one item on the output channel when enabled and the path is
// not empty, otherwise it is dropped.
// a pose item runs a nearest waypoint scan (one store read per cycle),
// then folds the lookahead into the path by repeated subtraction of the
// path length, then makes four passes of the shared cordic: each a
// normalise or reduce phase plus 13 iterations. in_stall stays high
// while one is busy.
// the result sits in an output register; a finished item waits there while
// out_stall is high, and the next item is taken meanwhile.
// reset empties the path and loads the register defaults; the store itself
// is not cleared. configuration writes take effect on the next cycle.
// ---------------------------------------------------------------------------
module stanley_path_tracking_steer_unit #(
  parameter int PATH_DEPTH = spt_pkg::PATH_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic              start_path,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [14:0] steer,
  output logic [14:0]       speed,
  output logic [7:0]        target_index,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import spt_pkg::*;

  spt_cmd_t  cmd_c;
  spt_stat_t stat;

  spt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .stat(stat), .cmd_c(cmd_c)
  );

  spt_dp #(.PATH_DEPTH(PATH_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .cmd_c(cmd_c), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start_path(start_path), .pos_x(pos_x), .pos_y(pos_y),
    .heading(heading), .quat_z(quat_z), .quat_w(quat_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .steer(steer), .speed(speed), .target_index(target_index)
  );

endmodule

/* rtl/spt_cordic.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spt_cordic
// shared iterative cordic: atan2 by vectoring, sin/cos by rotation
// ---------------------------------------------------------------------------
module spt_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start_vec,
  input  logic                         start_rot,
  input  logic signed [spt_pkg::CW-1:0] vec_y,
  input  logic signed [spt_pkg::CW-1:0] vec_x,
  input  logic signed [spt_pkg::ZW-1:0] rot_ang,
  output logic                         done,
  output logic signed [spt_pkg::ZW-1:0] z_out,
  output logic signed [spt_pkg::TW-1:0] cos_out,
  output logic signed [spt_pkg::TW-1:0] sin_out
);
  import spt_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_NORM = 3'd1;
  localparam logic [2:0] P_RED  = 3'd2;
  localparam logic [2:0] P_VRUN = 3'd3;
  localparam logic [2:0] P_RRUN = 3'd4;

  logic [2:0]           phase;
  logic signed [CW-1:0] x, y, m;
  logic signed [ZW-1:0] z;
  logic                 neg;
  logic [3:0]           i;

  logic signed [CW-1:0] sx, sy, ax, ay, xn, yn, xr, yr;
  logic signed [ZW-1:0] zn, tab;

  assign ax  = vec_x[CW-1] ? -vec_x : vec_x;
  assign ay  = vec_y[CW-1] ? -vec_y : vec_y;
  assign sx  = x >>> i;
  assign sy  = y >>> i;
  assign tab = atan_lut(i);

  always_comb begin
    if (phase == P_VRUN) begin
      if (!y[CW-1]) begin
        xn = x + sy; yn = y - sx; zn = z + tab;
      end else begin
        xn = x - sy; yn = y + sx; zn = z - tab;
      end
    end else begin
      if (!z[ZW-1]) begin
        xn = x - sy; yn = y + sx; zn = z - tab;
      end else begin
        xn = x + sy; yn = y - sx; zn = z + tab;
      end
    end
  end

  // round Q24.30 down to Q4.14
  assign xr = (xn + ROUND_HALF) >>> 16;
  assign yr = (yn + ROUND_HALF) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start_vec) begin
            x     <= vec_x;
            y     <= vec_y;
            m     <= (ax > ay) ? ax : ay;
            phase <= P_NORM;
          end else if (start_rot) begin
            x     <= CORDIC_K30;
            y     <= '0;
            z     <= rot_ang;
            neg   <= 1'b0;
            phase <= P_RED;
          end
        end
        P_NORM: begin
          if (m == '0) begin
            z_out <= '0;
            done  <= 1'b1;
            phase <= P_IDLE;
          end else if (m < NORM_LO) begin
            x <= x <<< 1; y <= y <<< 1; m <= m <<< 1;
          end else if (m >= NORM_HI) begin
            x <= x >>> 1; y <= y >>> 1; m <= m >>> 1;
          end else begin
            if (x[CW-1]) begin
              z <= y[CW-1] ? -ANG_PI : ANG_PI;
              x <= -x;
              y <= -y;
            end else begin
              z <= '0;
            end
            i     <= '0;
            phase <= P_VRUN;
          end
        end
        P_RED: begin
          if (z > ANG_HALF_PI) begin
            z <= z - ANG_PI; neg <= ~neg;
          end else if (z < -ANG_HALF_PI) begin
            z <= z + ANG_PI; neg <= ~neg;
          end else begin
            i     <= '0;
            phase <= P_RRUN;
          end
        end
        P_VRUN: begin
          x <= xn; y <= yn; z <= zn;
          i <= i + 4'd1;
          if (i == 4'(CORDIC_LAST)) begin
            z_out <= zn;
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        P_RRUN: begin
          x <= xn; y <= yn; z <= zn;
          i <= i + 4'd1;
          if (i == 4'(CORDIC_LAST)) begin
            cos_out <= neg ? -xr[TW-1:0] : xr[TW-1:0];
            sin_out <= neg ? -yr[TW-1:0] : yr[TW-1:0];
            done    <= 1'b1;
            phase   <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

/* rtl/spt_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spt_dp
// datapath: path store, nearest waypoint search, angle and speed arithmetic
// ---------------------------------------------------------------------------
module spt_dp #(
  parameter int PATH_DEPTH = spt_pkg::PATH_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  spt_pkg::spt_cmd_t cmd_c,
  output spt_pkg::spt_stat_t stat,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              start_path,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [14:0] steer,
  output logic [14:0]       speed,
  output logic [7:0]        target_index
);
  import spt_pkg::*;

  localparam int IDXW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CNTW = IDXW + 1;
  localparam int MW   = ((CNTW > 8) ? CNTW : 8) + 1;

  // configuration
  logic        enable;
  logic [15:0] gain;
  logic [14:0] tspeed, minspeed;
  logic [13:0] steer_lim;
  logic [7:0]  lookahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      gain      <= 16'd256;
      tspeed    <= 15'd384;
      minspeed  <= 15'd384;
      steer_lim <= 14'd8192;
      lookahead <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_GAIN:      gain      <= cfg_data;
        REG_TSPEED:    tspeed    <= cfg_data[14:0];
        REG_MINSPEED:  minspeed  <= cfg_data[14:0];
        REG_STEER_LIM: steer_lim <= cfg_data[13:0];
        REG_LOOKAHEAD: lookahead <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // path store
  spt_wp_t   mem [PATH_DEPTH];
  spt_wp_t   rdata, wdata;
  logic [CNTW-1:0] cnt, ra;
  logic [IDXW-1:0] raddr, waddr;
  logic            we, re, iss, srch_busy;
  logic [MW-1:0]   modv;

  assign wdata = '{x: pos_x, y: pos_y, qz: quat_z, qw: quat_w};
  assign we    = cmd_c.take_wp && (start_path || cnt < CNTW'(PATH_DEPTH));
  assign waddr = start_path ? '0 : cnt[IDXW-1:0];
  assign iss   = srch_busy && (ra < cnt);
  assign re    = iss || cmd_c.tgt_read;
  assign raddr = cmd_c.tgt_read ? modv[IDXW-1:0] : ra[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd_c.take_wp) begin
      if (start_path) cnt <= CNTW'(1);
      else if (cnt < CNTW'(PATH_DEPTH)) cnt <= cnt + CNTW'(1);
    end
  end

  // pose latch
  logic signed [15:0] px, py;
  logic signed [14:0] hd;
  always_ff @(posedge clk) begin
    if (cmd_c.take_pose) begin
      px <= pos_x;
      py <= pos_y;
      hd <= heading;
    end
  end

  // search pipeline: read, difference, square, compare
  logic            v1, v2, v3;
  logic [IDXW-1:0] idx1, idx2, idx3, best;
  logic signed [16:0] ddx, ddy;
  logic [33:0]     sqx, sqy, best_d, dsum;
  logic signed [33:0] px2, py2;

  assign px2  = ddx * ddx;
  assign py2  = ddy * ddy;
  assign dsum = sqx + sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      srch_busy <= 1'b0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (cmd_c.take_pose) srch_busy <= 1'b1;
      else if (cmd_c.mod_load) srch_busy <= 1'b0;
      v1 <= iss;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_c.take_pose) ra <= '0;
    else if (iss) ra <= ra + CNTW'(1);
    idx1 <= ra[IDXW-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    ddx  <= {rdata.x[15], rdata.x} - {px[15], px};
    ddy  <= {rdata.y[15], rdata.y} - {py[15], py};
    sqx  <= px2;
    sqy  <= py2;
    if (v3 && (idx3 == '0 || dsum < best_d)) begin
      best_d <= dsum;
      best   <= idx3;
    end
  end

  // target index by repeated subtraction of the path length
  always_ff @(posedge clk) begin
    if (cmd_c.mod_load) modv <= MW'(best) + MW'(lookahead);
    else if (cmd_c.mod_step) modv <= modv - MW'(cnt);
  end

  // angle arithmetic
  logic                  c_vec, c_rot, c_done;
  logic signed [CW-1:0]  c_y, c_x;
  logic signed [ZW-1:0]  c_ang, c_z;
  logic signed [TW-1:0]  c_cos, c_sin;
  logic signed [ZW-1:0]  err;
  logic signed [16:0]    tdx, tdy;
  logic signed [34:0]    p1;
  logic signed [35:0]    cte;
  logic signed [52:0]    gprod;
  logic signed [CW-1:0]  gc;
  logic signed [ZW:0]    sfull, lim;
  logic signed [33:0]    sprod, sp;
  logic signed [34:0]    p2;

  assign c_vec = cmd_c.at_q || cmd_c.at_g;
  assign c_rot = cmd_c.sc_hd || cmd_c.sc_err;
  assign c_y   = cmd_c.at_q ? CW'(rdata.qz) : gc;
  assign c_x   = cmd_c.at_q ? CW'(rdata.qw) : $signed({{(CW-37){1'b0}}, tspeed, 22'd0});
  assign c_ang = cmd_c.sc_hd ? ZW'(hd) : err;

  spt_cordic u_cordic (
    .clk(clk), .rst(rst),
    .start_vec(c_vec), .start_rot(c_rot),
    .vec_y(c_y), .vec_x(c_x), .rot_ang(c_ang),
    .done(c_done), .z_out(c_z), .cos_out(c_cos), .sin_out(c_sin)
  );

  assign tdx   = {rdata.x[15], rdata.x} - {px[15], px};
  assign tdy   = {rdata.y[15], rdata.y} - {py[15], py};
  assign p2    = tdx * c_sin;
  assign gprod = $signed({1'b0, gain}) * cte;
  assign sfull = (ZW+1)'(err) + (ZW+1)'(c_z);
  assign lim   = $signed({{(ZW-13){1'b0}}, steer_lim});
  assign sp    = sprod >>> 14;

  always_ff @(posedge clk) begin
    if (cmd_c.err_calc) err <= (c_z <<< 1) - ZW'(hd);
    else if (cmd_c.wrap_step) begin
      if (err > ANG_PI) err <= err - ANG_TWO_PI;
      else err <= err + ANG_TWO_PI;
    end
    if (cmd_c.cte_a) p1 <= tdy * c_cos;
    if (cmd_c.cte_b) cte <= 36'(p1) - 36'(p2);
    if (cmd_c.gmul) gc <= CW'(gprod);
    if (cmd_c.spd_mul) sprod <= $signed({1'b0, tspeed}) * c_cos;
  end

  logic signed [14:0] steer_r;
  always_ff @(posedge clk) begin
    if (cmd_c.steer_calc) begin
      priority if (sfull > lim) steer_r <= lim[14:0];
      else if (sfull < -lim) steer_r <= -lim[14:0];
      else steer_r <= sfull[14:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_c.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_c.res_load) begin
      steer        <= steer_r;
      target_index <= modv[7:0];
      priority if (sp < $signed({19'd0, minspeed})) speed <= minspeed;
      else if (sp > 34'sd32767) speed <= 15'h7fff;
      else speed <= sp[14:0];
    end
  end

  assign stat.pose_ok     = enable && (cnt != '0);
  assign stat.srch_done   = srch_busy && !iss && !v1 && !v2 && !v3;
  assign stat.mod_done    = modv < MW'(cnt);
  assign stat.wrap_done   = !(err > ANG_PI) && !(err <= -ANG_PI);
  assign stat.cordic_done = c_done;
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

/* rtl/spt_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spt_ctrl
// sequencer: takes items and steps the datapath through one pose update
// ---------------------------------------------------------------------------
module spt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  spt_pkg::spt_stat_t  stat,
  output spt_pkg::spt_cmd_t   cmd_c
);
  import spt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_RDT  = 4'd3;
  localparam logic [3:0] S_AT1  = 4'd4;
  localparam logic [3:0] S_WRAP = 4'd5;
  localparam logic [3:0] S_SC1  = 4'd6;
  localparam logic [3:0] S_CTE2 = 4'd7;
  localparam logic [3:0] S_GMUL = 4'd8;
  localparam logic [3:0] S_AT2S = 4'd9;
  localparam logic [3:0] S_AT2  = 4'd10;
  localparam logic [3:0] S_SC2  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd_c      = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_WAYPOINT) begin
            cmd_c.take_wp = 1'b1;
          end else if (stat.pose_ok) begin
            cmd_c.take_pose = 1'b1;
            state_next      = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (stat.srch_done) begin
          cmd_c.mod_load = 1'b1;
          state_next     = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          cmd_c.tgt_read = 1'b1;
          state_next     = S_RDT;
        end else begin
          cmd_c.mod_step = 1'b1;
        end
      end
      S_RDT: begin
        cmd_c.at_q = 1'b1;
        state_next = S_AT1;
      end
      S_AT1: begin
        if (stat.cordic_done) begin
          cmd_c.err_calc = 1'b1;
          state_next     = S_WRAP;
        end
      end
      S_WRAP: begin
        if (stat.wrap_done) begin
          cmd_c.sc_hd = 1'b1;
          state_next  = S_SC1;
        end else begin
          cmd_c.wrap_step = 1'b1;
        end
      end
      S_SC1: begin
        if (stat.cordic_done) begin
          cmd_c.cte_a = 1'b1;
          state_next  = S_CTE2;
        end
      end
      S_CTE2: begin
        cmd_c.cte_b = 1'b1;
        state_next  = S_GMUL;
      end
      S_GMUL: begin
        cmd_c.gmul = 1'b1;
        state_next = S_AT2S;
      end
      S_AT2S: begin
        cmd_c.at_g = 1'b1;
        state_next = S_AT2;
      end
      S_AT2: begin
        if (stat.cordic_done) begin
          cmd_c.steer_calc = 1'b1;
          cmd_c.sc_err     = 1'b1;
          state_next       = S_SC2;
        end
      end
      S_SC2: begin
        if (stat.cordic_done) begin
          cmd_c.spd_mul = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd_c.res_load = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
